/* sv/igfc_pkg.sv */
package igfc_pkg;

  localparam int CrcMinFrame = 4;
  localparam int CrcTail = 2;
  localparam int CrcBits = 8;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  localparam logic [1:0] ActBegin = 2'd0;
  localparam logic [1:0] ActByte = 2'd1;
  localparam logic [1:0] ActTick = 2'd2;
  localparam logic [1:0] ActFinish = 2'd3;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgAddrW-1:0] CfgGapMs = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgMaxFrameBytes = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgMaxFrames = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgMaxTotalBytes = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgDurationMs = 3'd4;

  localparam logic [15:0] GapMsReset = 16'd2;
  localparam logic [15:0] MaxFrameBytesReset = 16'd256;
  localparam logic [15:0] MaxFramesReset = 16'd64;
  localparam logic [23:0] MaxTotalBytesReset = 24'd4096;
  localparam logic [31:0] DurationMsReset = 32'd10000;

  localparam int InDataW = 40;
  localparam int OutDataW = 128;

  typedef struct packed {
    logic [15:0] gap_ms;
    logic [15:0] max_frame_bytes;
    logic [15:0] max_frames;
    logic [23:0] max_total_bytes;
    logic [31:0] duration_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] last_byte_time;
    logic        frame_open;
    logic [15:0] open_length;
    logic [31:0] open_offset;
    logic [31:0] open_gap;
    logic [15:0] crc_body;
    logic [7:0]  tail0;
    logic [7:0]  tail1;
    logic [15:0] closed_count;
    logic [15:0] crc_ok_count;
    logic [23:0] byte_total;
    logic        trunc_seen;
  } state_t;

  typedef struct packed {
    logic        byte_accepted;
    logic [7:0]  byte_out;
    logic        starts_frame;
    logic        frame_closed;
    logic [15:0] frame_length;
    logic [31:0] frame_offset_ms;
    logic [31:0] frame_gap_ms;
    logic        frame_crc_ok;
    logic [15:0] frames_total;
    logic [15:0] crc_ok_total;
    logic        truncated_flag;
    logic        capture_done;
  } result_t;

  localparam state_t StateReset = '{
    start_time: 32'd0, last_byte_time: 32'd0, frame_open: 1'b0, open_length: 16'd0,
    open_offset: 32'd0, open_gap: 32'd0, crc_body: CrcInit, tail0: 8'd0, tail1: 8'd0,
    closed_count: 16'd0, crc_ok_count: 16'd0, byte_total: 24'd0, trunc_seen: 1'b0
  };

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'd0, b};
    for (int i = 0; i < CrcBits; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic crc_match(input state_t s);
    return (s.open_length >= 16'(CrcMinFrame)) && (s.crc_body == {s.tail1, s.tail0});
  endfunction

  function automatic state_t close_frame(input state_t s);
    state_t r;
    r = s;
    if (r.closed_count != 16'hFFFF) begin
      r.closed_count = r.closed_count + 16'd1;
    end
    if (crc_match(s) && r.crc_ok_count != 16'hFFFF) begin
      r.crc_ok_count = r.crc_ok_count + 16'd1;
    end
    r.frame_open = 1'b0;
    r.open_length = 16'd0;
    r.open_offset = 32'd0;
    r.open_gap = 32'd0;
    r.crc_body = CrcInit;
    r.tail0 = 8'd0;
    r.tail1 = 8'd0;
    return r;
  endfunction

  function automatic state_t open_frame(input state_t s, input logic [31:0] off,
                                        input logic [31:0] gap);
    state_t r;
    r = s;
    r.frame_open = 1'b1;
    r.open_length = 16'd0;
    r.open_offset = off;
    r.open_gap = gap;
    r.crc_body = CrcInit;
    r.tail0 = 8'd0;
    r.tail1 = 8'd0;
    return r;
  endfunction

  function automatic state_t append_byte(input state_t s, input logic [7:0] b);
    state_t r;
    r = s;
    if (s.open_length >= 16'(CrcTail)) begin
      r.crc_body = crc16_byte(s.crc_body, s.tail0);
      r.tail0 = s.tail1;
      r.tail1 = b;
    end else if (s.open_length[0]) begin
      r.tail1 = b;
    end else begin
      r.tail0 = b;
    end
    if (s.open_length != 16'hFFFF) begin
      r.open_length = s.open_length + 16'd1;
    end
    if (s.byte_total != 24'hFFFFFF) begin
      r.byte_total = s.byte_total + 24'd1;
    end
    return r;
  endfunction

endpackage

/* sv/igfc_cfg.sv */
module igfc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [igfc_pkg::CfgAddrW-1:0] addr,
  input  logic [igfc_pkg::CfgDataW-1:0] wdata,
  output igfc_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_ms <= igfc_pkg::GapMsReset;
      cfg.max_frame_bytes <= igfc_pkg::MaxFrameBytesReset;
      cfg.max_frames <= igfc_pkg::MaxFramesReset;
      cfg.max_total_bytes <= igfc_pkg::MaxTotalBytesReset;
      cfg.duration_ms <= igfc_pkg::DurationMsReset;
    end else if (we) begin
      case (addr)
        igfc_pkg::CfgGapMs:         cfg.gap_ms <= wdata[15:0];
        igfc_pkg::CfgMaxFrameBytes: cfg.max_frame_bytes <= wdata[15:0];
        igfc_pkg::CfgMaxFrames:     cfg.max_frames <= wdata[15:0];
        igfc_pkg::CfgMaxTotalBytes: cfg.max_total_bytes <= wdata[23:0];
        igfc_pkg::CfgDurationMs:    cfg.duration_ms <= wdata[31:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/igfc_step.sv */
module igfc_step (
  input  igfc_pkg::cfg_t   cfg,
  input  igfc_pkg::state_t st,
  input  logic [1:0]       action,
  input  logic [7:0]       data_byte,
  input  logic [31:0]      now_ms,
  output igfc_pkg::state_t st_next,
  output igfc_pkg::result_t res
);

  always_comb begin
    igfc_pkg::state_t s;
    logic [31:0] since_last;
    logic [31:0] since_start;
    logic [15:0] fcap;
    logic        closed;
    logic        accepted;
    logic        starts;
    logic        drop;

    s = st;
    since_last = now_ms - st.last_byte_time;
    since_start = now_ms - st.start_time;
    fcap = (cfg.max_frame_bytes == 16'd0) ? 16'd1 : cfg.max_frame_bytes;
    closed = 1'b0;
    accepted = 1'b0;
    starts = 1'b0;
    drop = 1'b0;

    unique case (action)
      igfc_pkg::ActBegin: begin
        s.start_time = now_ms;
        s.last_byte_time = now_ms;
      end
      igfc_pkg::ActFinish: begin
        if (st.frame_open) begin
          s = igfc_pkg::close_frame(s);
          closed = 1'b1;
        end
      end
      igfc_pkg::ActByte, igfc_pkg::ActTick: begin
        // idle gap close
        if (st.frame_open && since_last >= {16'd0, cfg.gap_ms}) begin
          s = igfc_pkg::close_frame(s);
          closed = 1'b1;
        end
        if (action == igfc_pkg::ActByte) begin
          if (s.closed_count >= cfg.max_frames || s.byte_total >= cfg.max_total_bytes) begin
            s.trunc_seen = 1'b1;
          end else begin
            if (!s.frame_open) begin
              s = igfc_pkg::open_frame(s, since_start, since_last);
              starts = 1'b1;
            end else if (s.open_length >= fcap) begin
              // length cut
              s = igfc_pkg::close_frame(s);
              closed = 1'b1;
              if (s.closed_count >= cfg.max_frames) begin
                s.trunc_seen = 1'b1;
                drop = 1'b1;
              end else begin
                s = igfc_pkg::open_frame(s, since_start, 32'd0);
                starts = 1'b1;
              end
            end
            if (!drop) begin
              s = igfc_pkg::append_byte(s, data_byte);
              s.last_byte_time = now_ms;
              accepted = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    st_next = s;

    res.byte_accepted = accepted;
    res.byte_out = accepted ? data_byte : 8'd0;
    res.starts_frame = accepted && starts;
    res.frame_closed = closed;
    res.frame_length = closed ? st.open_length : 16'd0;
    res.frame_offset_ms = closed ? st.open_offset : 32'd0;
    res.frame_gap_ms = closed ? st.open_gap : 32'd0;
    res.frame_crc_ok = closed && igfc_pkg::crc_match(st);
    res.frames_total = s.closed_count;
    res.crc_ok_total = s.crc_ok_count;
    res.truncated_flag = s.trunc_seen;
    res.capture_done = s.trunc_seen || s.closed_count >= cfg.max_frames ||
                       s.byte_total >= cfg.max_total_bytes ||
                       (now_ms - s.start_time) >= cfg.duration_ms;
  end

endmodule

/* sv/idle_gap_frame_capture.sv */
// a request passes through the input register and then the result register before its result is valid
// throughput: one request per cycle unless m_tready back-pressures the output; the next-state
//   logic with its 8-step crc byte update is combinational, so back-to-back requests never stall internally
// reset: rst is synchronous, active high; clears frame state, counters, flags,
//   both handshake stages and returns all config registers to their defaults
module idle_gap_frame_capture (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [igfc_pkg::InDataW-1:0]  s_tdata,   // data_byte[7:0], now_ms[39:8]
  input  logic [1:0]                    s_tuser,   // action[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // byte_accepted[0], byte_out[8:1], starts_frame[9], frame_closed[10],
  // frame_length[26:11], frame_offset_ms[58:27], frame_gap_ms[90:59],
  // frame_crc_ok[91], frames_total[107:92], crc_ok_total[123:108],
  // truncated_flag[124], capture_done[125], zero pad[127:126]
  output logic [igfc_pkg::OutDataW-1:0] m_tdata,
  input  logic                          cfg_we,
  input  logic [igfc_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [igfc_pkg::CfgDataW-1:0] cfg_wdata
);

  igfc_pkg::cfg_t    cfg;
  igfc_pkg::state_t  st;
  igfc_pkg::state_t  st_next;
  igfc_pkg::result_t res;

  logic        in_valid;
  logic [1:0]  in_action;
  logic [7:0]  in_byte;
  logic [31:0] in_now;
  logic        adv;

  assign adv = !m_tvalid || m_tready;
  assign s_tready = !in_valid || adv;

  igfc_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .addr  (cfg_addr),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  igfc_step u_step (
    .cfg       (cfg),
    .st        (st),
    .action    (in_action),
    .data_byte (in_byte),
    .now_ms    (in_now),
    .st_next   (st_next),
    .res       (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser;
      in_byte <= s_tdata[7:0];
      in_now <= s_tdata[39:8];
    end
  end

  // state and result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= igfc_pkg::StateReset;
      m_tvalid <= 1'b0;
    end else if (in_valid && adv) begin
      st <= st_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (in_valid && adv) begin
      m_tdata <= {2'b00, res.capture_done, res.truncated_flag, res.crc_ok_total,
                  res.frames_total, res.frame_crc_ok, res.frame_gap_ms,
                  res.frame_offset_ms, res.frame_length, res.frame_closed,
                  res.starts_frame, res.byte_out, res.byte_accepted};
    end
  end

  a_start_needs_accept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tdata[0])
    else $error("frame start flagged without a captured byte");

  a_closed_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> m_tdata[26:11] != 16'd0)
    else $error("closed frame reported with zero length");

  a_trunc_sticky: assert property (@(posedge clk) disable iff (rst)
    st.trunc_seen |=> st.trunc_seen)
    else $error("truncated flag cleared without reset");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !st.frame_open |-> st.open_length == 16'd0 && st.crc_body == igfc_pkg::CrcInit)
    else $error("no open frame but frame state not cleared");

endmodule
